>>> design/aqi_pkg.sv
// Shared types, breakpoint tables and lookup functions for the air quality classifier.
package aqi_pkg;

    localparam int NUM_BREAKS = 7;
    localparam int NUM_LIMITS = 3;

    localparam logic [8:0] SUB_MAX = 9'd500;

    typedef logic [9:0]  t_brk_tab [0:NUM_BREAKS-1];
    typedef logic [8:0]  t_idx_tab [0:NUM_BREAKS-1];
    typedef logic [15:0] t_lim_tab [0:NUM_LIMITS-1];

    // Concentration breakpoints and the index value at each of them.
    localparam t_brk_tab FINE_BRK   = '{10'd0, 10'd12, 10'd55, 10'd150, 10'd250, 10'd350, 10'd500};
    localparam t_brk_tab COARSE_BRK = '{10'd0, 10'd50, 10'd150, 10'd350, 10'd420, 10'd500, 10'd600};
    localparam t_idx_tab IDX_BRK    = '{9'd0, 9'd50, 9'd100, 9'd200, 9'd300, 9'd400, 9'd500};

    // Gas thresholds.
    localparam t_lim_tab ECO2_LIM = '{16'd1000, 16'd2000, 16'd4000};
    localparam t_lim_tab TVOC_LIM = '{16'd250, 16'd2000, 16'd4000};

    // Band edges of the combined index.
    localparam logic [8:0] BAND1_EDGE = 9'd50;
    localparam logic [8:0] BAND2_EDGE = 9'd100;
    localparam logic [8:0] BAND3_EDGE = 9'd200;
    localparam logic [8:0] BAND4_EDGE = 9'd300;

    // Level held after reset, before any sample has been classified.
    localparam logic [2:0] LEVEL_NONE = 3'd5;

    // Request to and response from the shared divider.
    typedef struct packed {
        logic        start;
        logic [15:0] num;
        logic [8:0]  den;
    } t_div_req;

    typedef struct packed {
        logic       done;
        logic [6:0] quot;
    } t_div_rsp;

    // Segment set-up for one interpolation: base index, rounded numerator, doubled span.
    typedef struct packed {
        logic [8:0]  base;
        logic [15:0] num;
        logic [8:0]  den;
    } t_seg_setup;

    typedef struct packed {
        logic [2:0] level;
        logic [8:0] psi;
        logic       changed;
    } t_class;

    // Find the segment that holds the reading and form the division operands.
    function automatic t_seg_setup seg_setup(input t_brk_tab brk, input logic [15:0] x);
        logic [2:0]  seg;
        logic [8:0]  dpm;
        logic [6:0]  dpsi;
        logic [7:0]  diff;
        logic [14:0] prod;
        t_seg_setup  s;
        seg = 3'd0;
        for (int k = NUM_BREAKS - 1; k >= 1; k--) begin
            if (x < {6'd0, brk[k]}) begin
                seg = 3'(k);
            end
        end
        if (seg == 3'd0) begin
            // Reading at or above the top breakpoint saturates; quotient comes out as zero.
            s.base = SUB_MAX;
            s.num  = 16'd0;
            s.den  = 9'd1;
        end else begin
            dpm    = 9'(brk[seg] - brk[seg - 3'd1]);
            dpsi   = 7'(IDX_BRK[seg] - IDX_BRK[seg - 3'd1]);
            diff   = 8'(x[9:0] - brk[seg - 3'd1]);
            prod   = {7'd0, diff} * {8'd0, dpsi};
            s.base = IDX_BRK[seg - 3'd1];
            s.num  = {prod, 1'b0} + {7'd0, dpm};
            s.den  = {dpm[7:0], 1'b0};
        end
        return s;
    endfunction

    // Number of thresholds that the reading has reached.
    function automatic logic [1:0] thresh_level(input t_lim_tab lim, input logic [15:0] x);
        logic [1:0] lvl;
        lvl = 2'd3;
        for (int k = NUM_LIMITS - 1; k >= 0; k--) begin
            if (x < lim[k]) begin
                lvl = 2'(k);
            end
        end
        return lvl;
    endfunction

endpackage

>>> design/air_quality_index_classifier.sv
// Top level: sequencer around the shared divider, sample and result registers.
//
//  Channel | Handshake           | Beat contents
//  --------+---------------------+----------------------------------------------------------
//  input   | i_valid / o_stall   | i_pm25_sample, i_pm10_sample, i_eco2_sample, i_tvoc_sample
//  output  | o_valid / i_stall   | o_quality_level, o_psi_value, o_fine_subindex,
//          |                     | o_coarse_subindex, o_level_changed
//
// Each sample goes through two interpolations, each a set-up state and a division in the
// shared divider, then a classification state. The divider is used once for PM2.5 and
// once for PM10. The input stalls from acceptance until the result is registered, so a
// new sample is accepted only after the previous one is through.
// Reset is synchronous and active low; the previous level resets to "no level yet".
// The result register frees the input side while a result waits; a held result only
// delays the classification cycle of the following sample.
module air_quality_index_classifier
    import aqi_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [15:0] i_pm25_sample,
    input  logic [15:0] i_pm10_sample,
    input  logic [15:0] i_eco2_sample,
    input  logic [15:0] i_tvoc_sample,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_quality_level,
    output logic [8:0]  o_psi_value,
    output logic [8:0]  o_fine_subindex,
    output logic [8:0]  o_coarse_subindex,
    output logic        o_level_changed
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_WAIT,
        ST_CLASS
    } t_state;

    t_state      r_state;
    logic        r_chan;
    logic [15:0] r_pm25;
    logic [15:0] r_pm10;
    logic [15:0] r_eco2;
    logic [15:0] r_tvoc;
    logic [8:0]  r_base;
    logic [8:0]  r_fine;
    logic [8:0]  r_coarse;
    logic [2:0]  r_prev_level;
    logic        r_out_valid;
    logic [2:0]  r_out_level;
    logic [8:0]  r_out_psi;
    logic [8:0]  r_out_fine;
    logic [8:0]  r_out_coarse;
    logic        r_out_changed;

    t_seg_setup  setup;
    t_div_req    div_req;
    t_div_rsp    div_rsp;
    t_class      cls;
    logic [8:0]  n_sub;
    logic        in_beat;
    logic        out_free;

    assign o_stall  = (r_state != ST_IDLE);
    assign in_beat  = i_valid && (r_state == ST_IDLE);
    assign out_free = !r_out_valid || !i_stall;

    // Segment lookup for the pollutant now being interpolated.
    always_comb begin
        if (r_chan) begin
            setup = seg_setup(COARSE_BRK, r_pm10);
        end else begin
            setup = seg_setup(FINE_BRK, r_pm25);
        end
    end

    assign div_req.start = (r_state == ST_SETUP);
    assign div_req.num   = setup.num;
    assign div_req.den   = setup.den;

    aqi_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Sub-index is the segment base plus the rounded quotient.
    assign n_sub = 9'(r_base + {2'd0, div_rsp.quot});

    aqi_classify u_classify (
        .i_fine       (r_fine),
        .i_coarse     (r_coarse),
        .i_eco2       (r_eco2),
        .i_tvoc       (r_tvoc),
        .i_prev_level (r_prev_level),
        .o_class      (cls)
    );

    // Sequencer, sample capture and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_chan       <= 1'b0;
            r_prev_level <= LEVEL_NONE;
            r_out_valid  <= 1'b0;
        end else begin
            // A new result may replace the one that leaves in this same cycle.
            if ((r_state == ST_CLASS) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (in_beat) begin
                        r_pm25  <= i_pm25_sample;
                        r_pm10  <= i_pm10_sample;
                        r_eco2  <= i_eco2_sample;
                        r_tvoc  <= i_tvoc_sample;
                        r_chan  <= 1'b0;
                        r_state <= ST_SETUP;
                    end
                end
                ST_SETUP: begin
                    r_base  <= setup.base;
                    r_state <= ST_WAIT;
                end
                ST_WAIT: begin
                    if (div_rsp.done) begin
                        if (r_chan) begin
                            r_coarse <= n_sub;
                            r_state  <= ST_CLASS;
                        end else begin
                            r_fine  <= n_sub;
                            r_chan  <= 1'b1;
                            r_state <= ST_SETUP;
                        end
                    end
                end
                ST_CLASS: begin
                    if (out_free) begin
                        r_out_level   <= cls.level;
                        r_out_psi     <= cls.psi;
                        r_out_fine    <= r_fine;
                        r_out_coarse  <= r_coarse;
                        r_out_changed <= cls.changed;
                        r_prev_level  <= cls.level;
                        r_state       <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_valid           = r_out_valid;
    assign o_quality_level   = r_out_level;
    assign o_psi_value       = r_out_psi;
    assign o_fine_subindex   = r_out_fine;
    assign o_coarse_subindex = r_out_coarse;
    assign o_level_changed   = r_out_changed;

endmodule

>>> design/aqi_divider.sv
// Iterative compare-and-subtract divider shared by both sub-index interpolations.
module aqi_divider
    import aqi_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic [15:0] r_rem;
    logic [8:0]  r_den;
    logic [6:0]  r_quot;
    logic [2:0]  r_cnt;
    logic        r_busy;
    logic        r_done;

    logic [15:0] shifted_den;
    logic        take;

    // Divisor aligned to the quotient bit under trial.
    assign shifted_den = {7'd0, r_den} << r_cnt;
    assign take        = (r_rem >= shifted_den);

    // One quotient bit per cycle, most significant first; the quotient never exceeds 7 bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_rem  <= i_req.num;
                r_den  <= i_req.den;
                r_quot <= 7'd0;
                r_cnt  <= 3'd6;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (take) begin
                    r_rem <= r_rem - shifted_den;
                end
                r_quot <= {r_quot[5:0], take};
                r_cnt  <= r_cnt - 3'd1;
                if (r_cnt == 3'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;

endmodule

>>> design/aqi_classify.sv
// Combines the sub-indices and gas levels into the quality level and change flag.
module aqi_classify
    import aqi_pkg::*;
(
    input  logic [8:0]  i_fine,
    input  logic [8:0]  i_coarse,
    input  logic [15:0] i_eco2,
    input  logic [15:0] i_tvoc,
    input  logic [2:0]  i_prev_level,
    output t_class      o_class
);

    logic [8:0] psi;
    logic [2:0] band;
    logic [1:0] eco2_lvl;
    logic [1:0] tvoc_lvl;
    logic [1:0] voc_lvl;
    logic [2:0] level;

    // The larger sub-index is the overall index.
    assign psi = (i_fine > i_coarse) ? i_fine : i_coarse;

    // Band of the overall index; 300 and above is the top band.
    always_comb begin
        if (psi < BAND1_EDGE) begin
            band = 3'd0;
        end else if (psi < BAND2_EDGE) begin
            band = 3'd1;
        end else if (psi < BAND3_EDGE) begin
            band = 3'd2;
        end else if (psi < BAND4_EDGE) begin
            band = 3'd3;
        end else begin
            band = 3'd4;
        end
    end

    // Gas levels and the worst of everything.
    assign eco2_lvl = thresh_level(ECO2_LIM, i_eco2);
    assign tvoc_lvl = thresh_level(TVOC_LIM, i_tvoc);
    assign voc_lvl  = (eco2_lvl > tvoc_lvl) ? eco2_lvl : tvoc_lvl;
    assign level    = (band > {1'b0, voc_lvl}) ? band : {1'b0, voc_lvl};

    assign o_class.level   = level;
    assign o_class.psi     = psi;
    assign o_class.changed = (level != i_prev_level);

endmodule
